// ===== hdl/idc_pkg.sv =====
// Shared types and constants for the integer to decimal ASCII converter.
package idc_pkg;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJUST     = 4'd3;

  // Decimal digits needed for 2^w - 1 (1233/4096 approximates log10 of 2).
  function automatic int digits_for(input int w);
    return ((w * 1233) >>> 12) + 1;
  endfunction

endpackage

// ===== hdl/idc_ifs.sv =====
// Request and character channel interfaces.
interface idc_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   signed_value;

  modport source (output valid, output value, output signed_value, input ready);
  modport sink   (input valid, input value, input signed_value, output ready);
endinterface

interface idc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hdl/integer_to_decimal_ascii_core.sv =====
// Top level: binary to decimal ASCII converter built on a chain of BCD cells.
//
//  channel | dir | fields                      | accepted when
//  number  | in  | value, signed_value         | number.valid && number.ready
//  text    | out | character, last             | text.valid && text.ready
//
// One request at a time. A request runs shift-and-add-3 over all VALUE_WIDTH
// bits in the cell chain, then a sign step (if negative), a skip step that
// suppresses leading zeros, and an emit step for each remaining digit, with
// stalls on text. Reset (rst, synchronous) returns to idle and drops any
// pending character.
module integer_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  idc_in_if.sink           number,
  idc_out_if.source        text
);
  import idc_pkg::*;

  localparam int NUM_DIGITS = digits_for(VALUE_WIDTH);
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int BIT_W      = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONVERT,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] mag_sr;
  logic                   negative;
  logic [BIT_W-1:0]       bit_count;
  logic [CNT_W-1:0]       digit_count;
  logic                   out_valid;
  logic [7:0]             out_char;
  logic                   out_last;

  cell_mode_t             cell_mode;
  logic [NUM_DIGITS-1:0]  carry;
  logic [3:0]             digits [NUM_DIGITS];
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   in_negative;
  logic                   skip_zero;
  logic                   char_load;

  assign top_digit   = digits[NUM_DIGITS-1];
  assign out_free    = !out_valid || text.ready;
  assign in_negative = number.signed_value && number.value[VALUE_WIDTH-1];
  assign skip_zero   = (top_digit == 4'd0) && (digit_count != CNT_W'(1));
  assign char_load   = ((state == S_SIGN) || (state == S_EMIT)) && out_free;

  assign number.ready   = (state == S_IDLE);
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  always_comb begin
    cell_mode = CELL_HOLD;
    case (state)
      S_IDLE:    if (number.valid) cell_mode = CELL_CLEAR;
      S_CONVERT: cell_mode = CELL_DABBLE;
      S_SKIP:    if (skip_zero) cell_mode = CELL_SHIFT;
      S_EMIT:    if (out_free) cell_mode = CELL_SHIFT;
      default:   cell_mode = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = mag_sr[VALUE_WIDTH-1];
      assign digit_in = 4'd0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digits[i-1];
    end
    idc_digit_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode),
      .bit_in   (bit_in),
      .digit_in (digit_in),
      .bit_out  (carry[i]),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (char_load) begin
        out_valid <= 1'b1;
      end else if (text.valid && text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (number.valid) begin
            mag_sr    <= in_negative ? VALUE_WIDTH'(~number.value + 1'b1) : number.value;
            negative  <= in_negative;
            bit_count <= BIT_W'(VALUE_WIDTH - 1);
            state     <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          mag_sr <= {mag_sr[VALUE_WIDTH-2:0], 1'b0};
          if (bit_count == '0) begin
            digit_count <= CNT_W'(NUM_DIGITS);
            state       <= negative ? S_SIGN : S_SKIP;
          end else begin
            bit_count <= bit_count - 1'b1;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char  <= ASCII_MINUS;
            out_last  <= 1'b0;
            state     <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, always keeping the lowest digit
          if (skip_zero) begin
            digit_count <= digit_count - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char    <= ASCII_ZERO + {4'd0, top_digit};
            out_last    <= (digit_count == CNT_W'(1));
            digit_count <= digit_count - 1'b1;
            if (digit_count == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/idc_digit_cell.sv =====
// One BCD digit cell of the double-dabble / digit shift chain.
module idc_digit_cell (
  input  logic              clk,
  input  idc_pkg::cell_mode_t mode,
  input  logic              bit_in,
  input  logic [3:0]        digit_in,
  output logic              bit_out,
  output logic [3:0]        digit
);
  import idc_pkg::*;

  logic [3:0] adjusted;

  assign adjusted = (digit >= BCD_ADJUST_MIN) ? 4'(digit + BCD_ADJUST) : digit;
  // carry into the next cell comes from this cell's own register only
  assign bit_out  = adjusted[3];

  always_ff @(posedge clk) begin
    case (mode)
      CELL_CLEAR:  digit <= '0;
      CELL_DABBLE: digit <= {adjusted[2:0], bit_in};
      CELL_SHIFT:  digit <= digit_in;
      default:     digit <= digit;
    endcase
  end

endmodule
